// File: hdl/sbt_pkg.sv
// ---------------------------------------------------------------------------
// sbt_pkg
// Shared types and constants for the source byte tokeniser.
// ---------------------------------------------------------------------------
package sbt_pkg;

    localparam int KIND_BITS = 6;
    localparam int LEN_BITS  = 16;
    localparam int OUT_POS_BITS = 32;

    localparam logic [5:0] K_ERROR     = 6'd0;
    localparam logic [5:0] K_EOF       = 6'd1;
    localparam logic [5:0] K_UINT      = 6'd2;
    localparam logic [5:0] K_FLOAT     = 6'd3;
    localparam logic [5:0] K_IDENT     = 6'd4;
    localparam logic [5:0] K_STRING    = 6'd5;
    localparam logic [5:0] K_PUNCT     = 6'd6;
    localparam logic [5:0] K_OP        = 6'd15;
    localparam logic [5:0] K_OPEQ      = 6'd23;
    localparam logic [5:0] K_KEYWORD   = 6'd31;
    localparam logic [5:0] K_DIRECTIVE = 6'd57;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;

    // result item held between the front and back parts
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] end_pos;
        logic [15:0] len;
        logic [63:0] ival;
        logic [31:0] frac;
        logic        last;
    } t_token;

    // round(2^32 / 10^(k+1))
    function automatic logic [31:0] frac_step(input logic [3:0] k);
        logic [31:0] v;
        v = 32'd0;
        case (k)
            4'd0: v = 32'd429496730;
            4'd1: v = 32'd42949673;
            4'd2: v = 32'd4294967;
            4'd3: v = 32'd429497;
            4'd4: v = 32'd42950;
            4'd5: v = 32'd4295;
            4'd6: v = 32'd429;
            4'd7: v = 32'd43;
            4'd8: v = 32'd4;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] punct_code(input logic [7:0] b);
        logic [5:0] v;
        v = 6'd63;
        case (b)
            8'h28: v = 6'd0;
            8'h29: v = 6'd1;
            8'h7b: v = 6'd2;
            8'h7d: v = 6'd3;
            8'h5b: v = 6'd4;
            8'h5d: v = 6'd5;
            8'h3a: v = 6'd6;
            8'h3b: v = 6'd7;
            8'h2c: v = 6'd8;
            default: v = 6'd63;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] op_code(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd15;
        case (b)
            8'h3d: v = 4'd0;
            8'h2b: v = 4'd1;
            8'h2d: v = 4'd2;
            8'h2a: v = 4'd3;
            8'h2f: v = 4'd4;
            8'h25: v = 4'd5;
            8'h3c: v = 4'd6;
            8'h3e: v = 4'd7;
            default: v = 4'd15;
        endcase
        return v;
    endfunction

    // keyword table, zero padded, first char in bits [7:0]
    function automatic logic [71:0] kw_word(input logic [4:0] i);
        logic [71:0] v;
        v = '0;
        case (i)
            5'd0:  v = {24'd0, "tcurts"};
            5'd1:  v = {32'd0, "ssalc"};
            5'd2:  v = {8'd0,  "etalpmet"};
            5'd3:  v = {8'd0,  "emanepyt"};
            5'd4:  v = {32'd0, "gnisu"};
            5'd5:  v = "ecapseman";
            5'd6:  v = {40'd0, "diov"};
            5'd7:  v = {40'd0, "rahc"};
            5'd8:  v = {32'd0, "trohs"};
            5'd9:  v = {48'd0, "tni"};
            5'd10: v = {40'd0, "gnol"};
            5'd11: v = {8'd0,  "rotarepo"};
            5'd12: v = {32'd0, "taolf"};
            5'd13: v = {24'd0, "elbuod"};
            5'd14: v = {8'd0,  "dengisnu"};
            5'd15: v = {32'd0, "tsnoc"};
            5'd16: v = {56'd0, "fi"};
            5'd17: v = {40'd0, "file"};
            5'd18: v = {40'd0, "esle"};
            5'd19: v = {32'd0, "elihw"};
            5'd20: v = {48'd0, "rof"};
            5'd21: v = {40'd0, "eurt"};
            5'd22: v = {32'd0, "eslaf"};
            5'd23: v = {32'd0, "kaerb"};
            5'd24: v = {8'd0,  "eunitnoc"};
            5'd25: v = {24'd0, "nruter"};
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] i);
        logic [3:0] v;
        v = 4'd0;
        case (i)
            5'd0: v = 4'd6;  5'd1: v = 4'd5;  5'd2: v = 4'd8;  5'd3: v = 4'd8;
            5'd4: v = 4'd5;  5'd5: v = 4'd9;  5'd6: v = 4'd4;  5'd7: v = 4'd4;
            5'd8: v = 4'd5;  5'd9: v = 4'd3;  5'd10: v = 4'd4; 5'd11: v = 4'd8;
            5'd12: v = 4'd5; 5'd13: v = 4'd6; 5'd14: v = 4'd8; 5'd15: v = 4'd5;
            5'd16: v = 4'd2; 5'd17: v = 4'd4; 5'd18: v = 4'd4; 5'd19: v = 4'd5;
            5'd20: v = 4'd3; 5'd21: v = 4'd4; 5'd22: v = 4'd5; 5'd23: v = 4'd5;
            5'd24: v = 4'd8; 5'd25: v = 4'd6;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [71:0] dir_word(input logic [2:0] i);
        logic [71:0] v;
        v = '0;
        case (i)
            3'd0: v = {56'd0, "fi"};
            3'd1: v = {32'd0, "fedfi"};
            3'd2: v = {40'd0, "esle"};
            3'd3: v = {40'd0, "file"};
            3'd4: v = {48'd0, "dne"};
            3'd5: v = {16'd0, "edulcni"};
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] dir_len(input logic [2:0] i);
        logic [3:0] v;
        v = 4'd0;
        case (i)
            3'd0: v = 4'd2; 3'd1: v = 4'd5; 3'd2: v = 4'd4;
            3'd3: v = 4'd4; 3'd4: v = 4'd3; 3'd5: v = 4'd7;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/sbt_front.sv
// ---------------------------------------------------------------------------
// sbt_front
// Scanner: takes one byte a cycle while i_take is high, keeps the token state
// and hands up to three finished tokens per byte to the token queue.
// ---------------------------------------------------------------------------
module sbt_front #(
    parameter int POSITION_BITS   = 32,
    parameter int KEYWORD_CHARS   = 9,
    parameter int FRACTION_DIGITS = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_source_byte,
    input  logic                  i_is_last,
    output logic [1:0]            o_count,
    output sbt_pkg::t_token       o_tok0,
    output sbt_pkg::t_token       o_tok1,
    output sbt_pkg::t_token       o_tok2
);
    import sbt_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_DIRECT, M_INT, M_FRAC, M_STR,
        M_OP0, M_OP1, M_OP2, M_OP3, M_OP4, M_OP5, M_OP6, M_OP7
    } t_mode;

    localparam int WB = $clog2(KEYWORD_CHARS);

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [15:0]              r_len, n_len;
    logic [7:0]               r_word [KEYWORD_CHARS];
    logic [63:0]              r_int, n_int;
    logic [31:0]              r_frac, n_frac;
    logic [3:0]               r_fcnt, n_fcnt;
    logic                     r_esc, n_esc;
    logic                     r_ended, n_ended;

    logic                     wr_en;
    logic [WB-1:0]            wr_idx;
    logic [7:0]               wr_byte;

    t_token                   tok [3];
    logic [1:0]               cnt;

    logic [POSITION_BITS-1:0] p, pm1;
    logic [31:0]              p32, pm1_32;
    logic                     is_dig, is_alp, ws;
    logic [5:0]               pc;
    logic [3:0]               oc;
    logic [5:0]               kw_kind, dir_kind;
    logic [15:0]              len_inc;
    logic [3:0]               fdig;
    logic [67:0]              int_x10;

    // keyword match on a zero padded word of the given length
    function automatic logic [5:0] kw_find(input logic [71:0] w, input logic [15:0] wl);
        logic [5:0] v;
        v = K_IDENT;
        for (int i = 25; i >= 0; i--) begin
            if (wl == 16'(kw_len(5'(i))) && w == kw_word(5'(i)))
                v = K_KEYWORD + 6'(i);
        end
        return v;
    endfunction

    // directive match; no match falls back to #if
    function automatic logic [5:0] dir_find(input logic [71:0] w, input logic [15:0] wl);
        logic [5:0] v;
        v = K_DIRECTIVE;
        for (int i = 5; i >= 0; i--) begin
            if (wl == 16'(dir_len(3'(i))) && w == dir_word(3'(i)))
                v = K_DIRECTIVE + 6'(i);
        end
        return v;
    endfunction

    // keyword / directive lookup on the buffered word
    always_comb begin
        logic [71:0] w;
        logic [15:0] dl;
        w = '0;
        for (int k = 0; k < 9; k++) begin
            if (k < KEYWORD_CHARS && 16'(k) < r_len) w[8*k +: 8] = r_word[k];
        end
        kw_kind = K_IDENT;
        for (int i = 25; i >= 0; i--) begin
            if (r_len == 16'(kw_len(5'(i))) && w == kw_word(5'(i)))
                kw_kind = K_KEYWORD + 6'(i);
        end
        dl = r_len - 16'd1;
        w = '0;
        for (int k = 0; k < 9; k++) begin
            if (k < KEYWORD_CHARS && 16'(k) < dl) w[8*k +: 8] = r_word[k];
        end
        dir_kind = K_DIRECTIVE;
        for (int i = 5; i >= 0; i--) begin
            if (dl == 16'(dir_len(3'(i))) && w == dir_word(3'(i)))
                dir_kind = K_DIRECTIVE + 6'(i);
        end
    end

    always_comb begin
        p       = r_pos;
        pm1     = r_pos - 1'b1;
        p32     = 32'(64'(p));
        pm1_32  = 32'(64'(pm1));
        is_dig  = i_source_byte >= CH_ZERO && i_source_byte <= CH_NINE;
        is_alp  = (i_source_byte >= 8'h41 && i_source_byte <= 8'h5a) ||
                  (i_source_byte >= 8'h61 && i_source_byte <= 8'h7a);
        ws      = i_source_byte == CH_SP || i_source_byte == CH_NL;
        pc      = punct_code(i_source_byte);
        oc      = op_code(i_source_byte);
        len_inc = (r_len == 16'hffff) ? r_len : r_len + 16'd1;
        fdig    = 4'(i_source_byte - CH_ZERO);
        int_x10 = 68'({r_int, 3'b000}) + 68'({r_int, 1'b0}) + 68'(fdig);
    end

    always_comb begin
        logic        taken, flushed, reset_all;
        logic [31:0] fend;
        logic [15:0] wl;
        logic [71:0] nwi, nwd;
        logic [7:0]  nb;
        t_token      t;
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_len   = r_len;
        n_int   = r_int;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        n_esc   = r_esc;
        n_ended = r_ended;
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_byte = i_source_byte;
        cnt     = 2'd0;
        taken   = 1'b0;
        flushed = 1'b0;
        reset_all = 1'b0;
        fend    = pm1_32;
        wl      = '0;
        nwi     = '0;
        nwd     = '0;
        nb      = '0;
        t       = '0;
        tok[0]  = '0;
        tok[1]  = '0;
        tok[2]  = '0;

        if (i_take) begin
            if (r_ended) begin
                reset_all = i_is_last;
            end else begin
                // pending token: continue or flush
                if (i_source_byte != 8'd0) begin
                    case (r_mode)
                        M_IDENT: begin
                            if (is_dig || is_alp) begin
                                taken = 1'b1;
                                if (r_len < 16'(KEYWORD_CHARS)) begin
                                    wr_en  = 1'b1;
                                    wr_idx = WB'(r_len);
                                end
                                n_len = len_inc;
                            end
                        end
                        M_DIRECT: begin
                            if (is_alp) begin
                                taken = 1'b1;
                                wl = r_len - 16'd1;
                                if (wl < 16'(KEYWORD_CHARS)) begin
                                    wr_en  = 1'b1;
                                    wr_idx = WB'(wl);
                                end
                                n_len = len_inc;
                            end
                        end
                        M_INT: begin
                            if (i_source_byte == CH_DOT) begin
                                taken = 1'b1;
                                n_mode = M_FRAC;
                                n_len = len_inc;
                            end else if (is_dig) begin
                                taken = 1'b1;
                                n_int = int_x10[63:0];
                                n_len = len_inc;
                            end
                        end
                        M_FRAC: begin
                            if (is_dig) begin
                                taken = 1'b1;
                                if (r_fcnt < 4'(FRACTION_DIGITS)) begin
                                    n_frac = r_frac + 32'(fdig) * frac_step(r_fcnt);
                                    n_fcnt = r_fcnt + 4'd1;
                                end
                                n_len = len_inc;
                            end
                        end
                        M_STR: begin
                            taken = 1'b1;
                            n_len = len_inc;
                            if (r_esc) begin
                                n_esc = 1'b0;
                            end else if (i_source_byte == CH_BSL) begin
                                n_esc = 1'b1;
                            end else if (i_source_byte == CH_QUOTE) begin
                                t.kind = K_STRING;
                                t.end_pos = p32;
                                t.len = len_inc;
                                tok[cnt] = t;
                                cnt = cnt + 2'd1;
                                n_mode = M_IDLE;
                            end
                        end
                        M_IDLE: ;
                        default: begin
                            if (i_source_byte == CH_EQ) begin
                                taken = 1'b1;
                                t.kind = K_OPEQ + 6'(r_mode - M_OP0);
                                t.end_pos = p32;
                                t.len = 16'd2;
                                tok[cnt] = t;
                                cnt = cnt + 2'd1;
                                n_mode = M_IDLE;
                            end
                        end
                    endcase
                    if (!taken && r_mode != M_IDLE) flushed = 1'b1;
                end else begin
                    flushed = r_mode != M_IDLE;
                end

                if (flushed) begin
                    t = '0;
                    t.end_pos = pm1_32;
                    t.len = r_len;
                    case (r_mode)
                        M_IDENT:  t.kind = kw_kind;
                        M_DIRECT: t.kind = dir_kind;
                        M_INT: begin
                            t.kind = K_UINT;
                            t.ival = r_int;
                        end
                        M_FRAC: begin
                            t.kind = K_FLOAT;
                            t.ival = r_int;
                            t.frac = r_frac;
                        end
                        M_STR:    t.kind = K_STRING;
                        default:  t.kind = K_OP + 6'(r_mode - M_OP0);
                    endcase
                    tok[cnt] = t;
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end

                if (i_source_byte == 8'd0) begin
                    t = '0;
                    t.kind = K_EOF;
                    t.end_pos = pm1_32;
                    tok[cnt] = t;
                    cnt = cnt + 2'd1;
                    if (i_is_last) reset_all = 1'b1;
                    else n_ended = 1'b1;
                end else begin
                    if (!taken && !ws) begin
                        n_len = 16'd1;
                        t = '0;
                        t.end_pos = p32;
                        t.len = 16'd1;
                        if (is_dig) begin
                            n_mode = M_INT;
                            n_int  = 64'(fdig);
                            n_frac = '0;
                            n_fcnt = '0;
                        end else if (is_alp) begin
                            n_mode = M_IDENT;
                            wr_en  = 1'b1;
                            wr_idx = '0;
                        end else if (i_source_byte == CH_HASH) begin
                            n_mode = M_DIRECT;
                        end else if (i_source_byte == CH_QUOTE) begin
                            n_mode = M_STR;
                            n_esc  = 1'b0;
                        end else if (pc != 6'd63) begin
                            t.kind = K_PUNCT + pc;
                            tok[cnt] = t;
                            cnt = cnt + 2'd1;
                        end else if (oc != 4'd15) begin
                            n_mode = t_mode'(4'(M_OP0) + oc);
                        end else begin
                            t.kind = K_ERROR;
                            tok[cnt] = t;
                            cnt = cnt + 2'd1;
                        end
                    end
                    n_pos = p + 1'b1;
                    if (i_is_last) begin
                        // word as it stands once this byte is written
                        for (int k = 0; k < 9; k++) begin
                            if (k < KEYWORD_CHARS) begin
                                nb = (wr_en && 32'(wr_idx) == k) ? wr_byte : r_word[k];
                                if (16'(k) < n_len) nwi[8*k +: 8] = nb;
                                if (16'(k) + 16'd1 < n_len) nwd[8*k +: 8] = nb;
                            end
                        end
                        // final flush of whatever is pending after this byte
                        t = '0;
                        t.end_pos = p32;
                        t.len = n_len;
                        fend = p32;
                        if (n_mode != M_IDLE) begin
                            case (n_mode)
                                M_IDENT: t.kind = kw_find(nwi, n_len);
                                M_DIRECT: t.kind = dir_find(nwd, n_len - 16'd1);
                                M_INT: begin
                                    t.kind = K_UINT;
                                    t.ival = n_int;
                                end
                                M_FRAC: begin
                                    t.kind = K_FLOAT;
                                    t.ival = n_int;
                                    t.frac = n_frac;
                                end
                                M_STR: t.kind = K_STRING;
                                default: t.kind = K_OP + 6'(n_mode - M_OP0);
                            endcase
                            tok[cnt] = t;
                            cnt = cnt + 2'd1;
                        end
                        t = '0;
                        t.kind = K_EOF;
                        t.end_pos = fend;
                        tok[cnt] = t;
                        cnt = cnt + 2'd1;
                        reset_all = 1'b1;
                    end
                end
            end
            if (reset_all) begin
                n_mode = M_IDLE; n_pos = '0; n_len = '0; n_int = '0;
                n_frac = '0; n_fcnt = '0; n_esc = 1'b0; n_ended = 1'b0;
            end
        end
        if (cnt != 2'd0) tok[cnt - 2'd1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_len   <= '0;
            r_int   <= '0;
            r_frac  <= '0;
            r_fcnt  <= '0;
            r_esc   <= 1'b0;
            r_ended <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            r_esc   <= n_esc;
            r_ended <= n_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_word[wr_idx] <= wr_byte;
    end

    assign o_count = cnt;
    assign o_tok0  = tok[0];
    assign o_tok1  = tok[1];
    assign o_tok2  = tok[2];

`ifndef NO_ASSERTIONS
    a_ended_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> o_count == 2'd0)
        else $error("tokens produced after end of source");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != M_IDLE |-> r_len != 16'd0)
        else $error("pending token with zero length");
    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_is_last |=> r_mode == M_IDLE && r_pos == '0)
        else $error("state not cleared after last byte");
`endif

endmodule

// File: hdl/sbt_queue.sv
// ---------------------------------------------------------------------------
// sbt_queue
// Token queue: takes up to three tokens a cycle; gives one a cycle on pop.
// ---------------------------------------------------------------------------
module sbt_queue #(
    parameter int DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_count,
    input  sbt_pkg::t_token i_tok0,
    input  sbt_pkg::t_token i_tok1,
    input  sbt_pkg::t_token i_tok2,
    input  logic            i_pop,
    output logic            o_room,
    output logic            o_empty,
    output sbt_pkg::t_token o_head
);
    import sbt_pkg::*;

    localparam int AB = $clog2(DEPTH);

    t_token          r_mem [DEPTH];
    logic [AB-1:0]   r_wp, r_rp;
    logic [AB:0]     r_fill, n_fill;
    logic            pop_ok;

    assign pop_ok  = i_pop && r_fill != '0;
    assign o_empty = r_fill == '0;
    assign o_head  = r_mem[r_rp];
    // three free slots guarantee a worst-case byte fits
    assign o_room  = r_fill <= (AB+1)'(DEPTH - 3);
    assign n_fill  = r_fill + (AB+1)'(i_count) - (AB+1)'(pop_ok);

    always_ff @(posedge i_clk) begin
        if (i_count > 2'd0) r_mem[r_wp] <= i_tok0;
        if (i_count > 2'd1) r_mem[AB'(r_wp + 1'b1)] <= i_tok1;
        if (i_count > 2'd2) r_mem[AB'(r_wp + 2'd2)] <= i_tok2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            r_wp   <= r_wp + AB'(i_count);
            r_rp   <= r_rp + AB'(pop_ok);
            r_fill <= n_fill;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_room |-> i_count == 2'd0)
        else $error("queue written while full");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (AB+1)'(DEPTH))
        else $error("queue fill beyond depth");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AB'(r_wp - r_rp) == AB'(r_fill))
        else $error("pointers disagree with fill");
`endif

endmodule

// File: hdl/source_byte_tokenizer.sv
// ---------------------------------------------------------------------------
// source_byte_tokenizer
// Streaming lexer: one source byte in, up to three tokens out, queued.
// ---------------------------------------------------------------------------
// channel  direction  handshake     payload
// byte     in         push / full   source_byte, is_last
// token    out        pop / empty   kind, end position, length, values, last
//
// One byte is taken every cycle while the token queue has three free slots.
// Tokens leave one per cycle; a byte giving several tokens uses queue space.
// A token is queued when the byte ending it is taken; the oldest one shows.
// Synchronous reset clears scanner state and empties the queue.
// ---------------------------------------------------------------------------
module source_byte_tokenizer #(
    parameter int POSITION_BITS   = 32,
    parameter int KEYWORD_CHARS   = 9,
    parameter int FRACTION_DIGITS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_source_byte,
    input  logic        i_is_last,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_token_kind,
    output logic [31:0] o_end_position,
    output logic [15:0] o_token_length,
    output logic [63:0] o_int_value,
    output logic [31:0] o_fraction_value,
    output logic        o_last_of_run
);
    import sbt_pkg::*;

    logic       take, room;
    logic [1:0] cnt;
    t_token     t0, t1, t2, head;

    assign full = !room;
    assign take = push && room;

    sbt_front #(
        .POSITION_BITS  (POSITION_BITS),
        .KEYWORD_CHARS  (KEYWORD_CHARS),
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_source_byte(i_source_byte),
        .i_is_last    (i_is_last),
        .o_count      (cnt),
        .o_tok0       (t0),
        .o_tok1       (t1),
        .o_tok2       (t2)
    );

    sbt_queue #(.DEPTH(8)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_count(cnt),
        .i_tok0 (t0),
        .i_tok1 (t1),
        .i_tok2 (t2),
        .i_pop  (pop),
        .o_room (room),
        .o_empty(empty),
        .o_head (head)
    );

    assign o_token_kind     = head.kind;
    assign o_end_position   = head.end_pos;
    assign o_token_length   = head.len;
    assign o_int_value      = head.ival;
    assign o_fraction_value = head.frac;
    assign o_last_of_run    = head.last;

`ifndef NO_ASSERTIONS
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> cnt == 2'd0)
        else $error("tokens made while full");
    a_token_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt != 2'd0 |=> !empty)
        else $error("token lost");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_token_kind <= 6'd62)
        else $error("bad token kind");
`endif

endmodule
